@@ src/crc32gc_pkg.sv @@
// Package for the CRC-32 generate and check unit.
// Holds the transaction types and the polynomial constants; depends on nothing.
`default_nettype none

package crc32gc_pkg;

    localparam int unsigned CRC_WIDTH = 32;
    localparam int unsigned DATA_WIDTH = 8;
    localparam logic [CRC_WIDTH-1:0] CRC_POLY = 32'h04C1_1DB7;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] data_byte;
        logic                  last_byte;
        logic [CRC_WIDTH-1:0]  expected_crc;
    } t_in_item;

    typedef struct packed {
        logic [CRC_WIDTH-1:0] crc_value;
        logic                 crc_ok;
    } t_out_item;

endpackage

`default_nettype wire

@@ src/crc32gc_step.sv @@
// Combinational remainder update for one message item, most significant bit first.
// Depends on crc32gc_pkg for the polynomial and widths.
`default_nettype none

module crc32gc_step #(
    parameter int unsigned BITS_PER_ITEM = 8
) (
    input  wire logic [crc32gc_pkg::CRC_WIDTH-1:0]  i_remainder,
    input  wire logic [crc32gc_pkg::DATA_WIDTH-1:0] i_data,
    output logic      [crc32gc_pkg::CRC_WIDTH-1:0]  o_remainder
);

    // Bits above the data field are fed as zeros.
    logic [63:0] w_data;
    assign w_data = {{(64 - crc32gc_pkg::DATA_WIDTH){1'b0}}, i_data};

    always_comb begin
        logic [crc32gc_pkg::CRC_WIDTH-1:0] v_rem;
        logic                              v_top;
        v_rem = i_remainder;
        for (int i = BITS_PER_ITEM - 1; i >= 0; i--) begin
            v_top = v_rem[crc32gc_pkg::CRC_WIDTH-1] ^ w_data[i];
            v_rem = {v_rem[crc32gc_pkg::CRC_WIDTH-2:0], 1'b0};
            if (v_top) begin
                v_rem = v_rem ^ crc32gc_pkg::CRC_POLY;
            end
        end
        o_remainder = v_rem;
    end

endmodule

`default_nettype wire

@@ src/crc32gc_out_reg.sv @@
// Result register with valid and stall toward the downstream receiver.
// Depends on crc32gc_pkg for the result transaction type.
`default_nettype none

module crc32gc_out_reg (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire crc32gc_pkg::t_out_item i_data,
    output logic                        o_free,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output crc32gc_pkg::t_out_item      o_data
);

    logic                   r_valid;
    logic                   n_valid;
    crc32gc_pkg::t_out_item r_data;

    // The register can take a new result when empty or when its content leaves now.
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ src/crc32_generate_and_check_unit.sv @@
// Top level of the CRC-32 generate and check unit.
// Depends on crc32gc_pkg, crc32gc_step and crc32gc_out_reg.
//
// Message bytes arrive on the input channel (i_in_valid, o_in_stall, i_in_data), one
// byte per transaction, most significant bit first. The running remainder starts at
// zero and follows the CRC-32 polynomial 0x04C11DB7 without reflection. The byte
// flagged by last_byte closes the message: one result transaction leaves on the output
// channel (o_out_valid, i_out_stall, o_out_data) carrying the inverted remainder, and
// in check mode a pass flag that is set when the remainder equals the inverted
// expected checksum. The remainder then returns to zero for the next message.
// Other bytes produce no result.
// The check_mode register is written through the configuration channel (i_cfg_valid,
// o_cfg_ready, i_cfg_data); it is always ready and should be written while idle.
// An accepted byte lands in an input register; the clock edge on which it moves on updates
// the remainder and, for a last byte, loads the result register, so a result passes through
// the input and result registers. One byte is taken every cycle while o_in_stall is low;
// the rate is set by the single XOR network between the input and result registers.
// When the receiver stalls while a result waits, the bytes of the next message still
// flow; only a further last byte holds in the input register, and then o_in_stall
// rises. Reset clears the remainder, check_mode and all valid flags.
`default_nettype none

module crc32_generate_and_check_unit #(
    parameter int unsigned BITS_PER_ITEM = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire crc32gc_pkg::t_in_item  i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output crc32gc_pkg::t_out_item      o_out_data,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic                   i_cfg_data
);

    logic                              r_check_mode;
    logic                              r_in_valid;
    logic                              n_in_valid;
    crc32gc_pkg::t_in_item             r_in;
    logic [crc32gc_pkg::CRC_WIDTH-1:0] r_rem;
    logic [crc32gc_pkg::CRC_WIDTH-1:0] n_rem;
    logic [crc32gc_pkg::CRC_WIDTH-1:0] w_rem_step;
    logic                              w_out_free;
    logic                              w_advance;
    logic                              w_accept;
    logic                              w_emit;
    crc32gc_pkg::t_out_item            w_result;

    // Configuration: a single register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_check_mode <= i_cfg_data;
        end
    end

    // The held byte moves on unless it closes a message and the result register is full.
    assign w_advance  = r_in_valid && (!r_in.last_byte || w_out_free);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_emit     = w_advance && r_in.last_byte;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
    end

    crc32gc_step #(
        .BITS_PER_ITEM (BITS_PER_ITEM)
    ) u_step (
        .i_remainder (r_rem),
        .i_data      (r_in.data_byte),
        .o_remainder (w_rem_step)
    );

    // The remainder clears once a message's result has been formed.
    always_comb begin
        n_rem = r_rem;
        if (w_advance) begin
            n_rem = r_in.last_byte ? '0 : w_rem_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

    assign w_result.crc_value = ~w_rem_step;
    assign w_result.crc_ok    = r_check_mode && (w_rem_step == ~r_in.expected_crc);

    crc32gc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_emit),
        .i_data  (w_result),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_rem_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_rem == '0)
        else $error("remainder not cleared after a message closed");

    a_held_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in))
        else $error("held input byte lost or overwritten");

    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_emit))
        else $error("result appeared without a closing byte");

    a_ok_needs_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.crc_ok |-> r_check_mode)
        else $error("pass flag set outside check mode");
`endif

endmodule

`default_nettype wire
